@@ sv/tftws_pkg.sv @@
// ----------------------------------------------------------------------------
// tftws_pkg
// Shared codes and constants for the TFT window fill sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tftws_pkg;

    localparam int CMD_W  = 3;
    localparam int PANEL_W = 11;
    localparam int COLOR_W = 16;
    localparam int BYTE_W  = 8;
    localparam int STEP_W  = 4;
    localparam int BOUND_W = 16;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RAW_CMD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RAW_DATA = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PIXEL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FILL     = 3'd4;

    // Configuration register indexes
    localparam logic REG_PANEL_WIDTH  = 1'b0;
    localparam logic REG_PANEL_HEIGHT = 1'b1;

    localparam logic [PANEL_W-1:0] PANEL_WIDTH_RST  = 11'd240;
    localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RST = 11'd320;

    // Panel command bytes
    localparam logic [BYTE_W-1:0] PANEL_CASET = 8'h2A;
    localparam logic [BYTE_W-1:0] PANEL_RASET = 8'h2B;
    localparam logic [BYTE_W-1:0] PANEL_RAMWR = 8'h2C;

    // Header step positions
    localparam logic [STEP_W-1:0] STEP_CASET = 4'd0;
    localparam logic [STEP_W-1:0] STEP_RASET = 4'd5;
    localparam logic [STEP_W-1:0] STEP_RAMWR = 4'd10;

endpackage

`default_nettype wire

@@ sv/tft_window_fill_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// tft_window_fill_sequencer_core
// Turns display commands into the byte stream for a serial TFT panel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction.
//   Raw command/data, draw pixel and fill rectangle items load a sequence;
//   they are dropped while a sequence is still pending. Each tick item
//   releases the next byte of the pending sequence on the output channel
//   (out_valid/out_ready) together with its DC flag and a last flag, after
//   which chip select may be released. A tick while idle gives nothing.
//   Pixel/fill sequences: 0x2A + 4 bounds bytes, 0x2B + 4 bounds bytes,
//   0x2C, then colour high/low bytes per pixel.
//   A byte enters the output register in the cycle after its tick is taken.
//   Throughput: one item per cycle unless the output stalls; all work is
//   done in one pass from the state registers into the output register.
//   A stalled receiver holds the output register; in_ready then stays low
//   until the waiting byte is taken.
//   Reset clears the sequence state, sets panel size to 240 x 320 and
//   empties the output register. Panel size is written through cfg_we.
// ----------------------------------------------------------------------------
`default_nettype none

module tft_window_fill_sequencer_core #(
    parameter int COORD_BITS = 12
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire                                  cfg_index,
    input  wire [tftws_pkg::PANEL_W-1:0]         cfg_data,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire [tftws_pkg::CMD_W-1:0]           command,
    input  wire signed [COORD_BITS-1:0]          pos_x,
    input  wire signed [COORD_BITS-1:0]          pos_y,
    input  wire signed [COORD_BITS-1:0]          rect_w,
    input  wire signed [COORD_BITS-1:0]          rect_h,
    input  wire [tftws_pkg::COLOR_W-1:0]         pixel_color,
    input  wire [tftws_pkg::BYTE_W-1:0]          raw_byte,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic [tftws_pkg::BYTE_W-1:0]         spi_byte,
    output logic                                 is_data,
    output logic                                 last
);
    import tftws_pkg::*;

    // Arithmetic width: room for pos + size and panel - pos, at least 16 bits
    localparam int AW    = (COORD_BITS + 2 > BOUND_W) ? COORD_BITS + 2 : BOUND_W;
    localparam int CNT_W = COORD_BITS + 1;

    typedef enum logic [1:0] {MODE_RAW, MODE_HDR, MODE_PIX} mode_t;

    localparam logic signed [AW-1:0] ONE_S = AW'(1);
    localparam logic [CNT_W-1:0]     ONE_C = CNT_W'(1);

    logic [PANEL_W-1:0] panel_width_reg, panel_height_reg;
    logic               busy_reg, busy_next;
    mode_t              mode_reg, mode_next;
    logic [STEP_W-1:0]  header_step_reg, header_step_next;
    logic [BYTE_W-1:0]  held_byte_reg, held_byte_next;
    logic               held_is_data_reg, held_is_data_next;
    logic [BOUND_W-1:0] x0_reg, x0_next, x1_reg, x1_next;
    logic [BOUND_W-1:0] y0_reg, y0_next, y1_reg, y1_next;
    logic [COLOR_W-1:0] held_color_reg, held_color_next;
    logic [CNT_W-1:0]   cols_in_row_reg, cols_in_row_next;
    logic [CNT_W-1:0]   cols_left_reg, cols_left_next;
    logic [CNT_W-1:0]   rows_left_reg, rows_left_next;
    logic               low_byte_next_reg, low_byte_next_next;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  spi_byte_reg, spi_byte_next;
    logic               is_data_reg, is_data_next;
    logic               last_reg, last_next;

    logic in_fire;

    // Clipping arithmetic
    logic signed [AW-1:0] x_s, y_s, w_s, h_s, pw_s, ph_s;
    logic signed [AW-1:0] w_clip, h_clip, x_end, y_end;
    logic                 pix_ok, fill_ok, fill_nonempty;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign spi_byte  = spi_byte_reg;
    assign is_data   = is_data_reg;
    assign last      = last_reg;

    always_comb
    begin
        x_s  = AW'(pos_x);
        y_s  = AW'(pos_y);
        w_s  = AW'(rect_w);
        h_s  = AW'(rect_h);
        pw_s = AW'(panel_width_reg);
        ph_s = AW'(panel_height_reg);

        pix_ok  = (x_s >= 0) && (x_s < pw_s) && (y_s >= 0) && (y_s < ph_s);
        fill_ok = (x_s < pw_s) && (y_s < ph_s);

        w_clip = (x_s + w_s - ONE_S >= pw_s) ? pw_s - x_s : w_s;
        h_clip = (y_s + h_s - ONE_S >= ph_s) ? ph_s - y_s : h_s;
        x_end  = x_s + w_clip - ONE_S;
        y_end  = y_s + h_clip - ONE_S;
        fill_nonempty = (w_clip > 0) && (h_clip > 0);
    end

    always_comb
    begin
        busy_next          = busy_reg;
        mode_next          = mode_reg;
        header_step_next   = header_step_reg;
        held_byte_next     = held_byte_reg;
        held_is_data_next  = held_is_data_reg;
        x0_next            = x0_reg;
        x1_next            = x1_reg;
        y0_next            = y0_reg;
        y1_next            = y1_reg;
        held_color_next    = held_color_reg;
        cols_in_row_next   = cols_in_row_reg;
        cols_left_next     = cols_left_reg;
        rows_left_next     = rows_left_reg;
        low_byte_next_next = low_byte_next_reg;

        out_valid_next = out_valid_reg && !out_ready;
        spi_byte_next  = spi_byte_reg;
        is_data_next   = is_data_reg;
        last_next      = last_reg;

        if (in_fire)
        begin
            if (command != CMD_TICK)
            begin
                if (!busy_reg)
                begin
                    if (command == CMD_RAW_CMD || command == CMD_RAW_DATA)
                    begin
                        held_byte_next    = raw_byte;
                        held_is_data_next = (command == CMD_RAW_DATA);
                        mode_next         = MODE_RAW;
                        busy_next         = 1'b1;
                    end
                    else if ((command == CMD_PIXEL && pix_ok) ||
                             (command == CMD_FILL && fill_ok))
                    begin
                        x0_next          = x_s[BOUND_W-1:0];
                        y0_next          = y_s[BOUND_W-1:0];
                        held_color_next  = pixel_color;
                        mode_next        = MODE_HDR;
                        header_step_next = STEP_CASET;
                        low_byte_next_next = 1'b0;
                        busy_next        = 1'b1;
                        if (command == CMD_PIXEL)
                        begin
                            x1_next          = x_s[BOUND_W-1:0] + BOUND_W'(1);
                            y1_next          = y_s[BOUND_W-1:0] + BOUND_W'(1);
                            cols_in_row_next = ONE_C;
                            cols_left_next   = ONE_C;
                            rows_left_next   = ONE_C;
                        end
                        else
                        begin
                            x1_next = x_end[BOUND_W-1:0];
                            y1_next = y_end[BOUND_W-1:0];
                            if (fill_nonempty)
                            begin
                                cols_in_row_next = w_clip[CNT_W-1:0];
                                cols_left_next   = w_clip[CNT_W-1:0];
                                rows_left_next   = h_clip[CNT_W-1:0];
                            end
                            else
                            begin
                                cols_in_row_next = '0;
                                cols_left_next   = '0;
                                rows_left_next   = '0;
                            end
                        end
                    end
                end
            end
            else if (busy_reg)
            begin
                out_valid_next = 1'b1;
                is_data_next   = 1'b0;
                last_next      = 1'b0;
                unique case (mode_reg)
                    MODE_RAW:
                    begin
                        spi_byte_next = held_byte_reg;
                        is_data_next  = held_is_data_reg;
                        last_next     = 1'b1;
                        busy_next     = 1'b0;
                    end
                    MODE_HDR:
                    begin
                        is_data_next = 1'b1;
                        case (header_step_reg)
                            STEP_CASET:
                            begin
                                spi_byte_next = PANEL_CASET;
                                is_data_next  = 1'b0;
                            end
                            STEP_CASET + 4'd1: spi_byte_next = x0_reg[15:8];
                            STEP_CASET + 4'd2: spi_byte_next = x0_reg[7:0];
                            STEP_CASET + 4'd3: spi_byte_next = x1_reg[15:8];
                            STEP_CASET + 4'd4: spi_byte_next = x1_reg[7:0];
                            STEP_RASET:
                            begin
                                spi_byte_next = PANEL_RASET;
                                is_data_next  = 1'b0;
                            end
                            STEP_RASET + 4'd1: spi_byte_next = y0_reg[15:8];
                            STEP_RASET + 4'd2: spi_byte_next = y0_reg[7:0];
                            STEP_RASET + 4'd3: spi_byte_next = y1_reg[15:8];
                            STEP_RASET + 4'd4: spi_byte_next = y1_reg[7:0];
                            default:
                            begin
                                spi_byte_next = PANEL_RAMWR;
                                is_data_next  = 1'b0;
                            end
                        endcase
                        if (header_step_reg >= STEP_RAMWR)
                        begin
                            header_step_next = STEP_CASET;
                            if (rows_left_reg == '0 || cols_in_row_reg == '0)
                            begin
                                last_next = 1'b1;
                                busy_next = 1'b0;
                                mode_next = MODE_RAW;
                            end
                            else
                            begin
                                mode_next          = MODE_PIX;
                                low_byte_next_next = 1'b0;
                            end
                        end
                        else
                        begin
                            header_step_next = header_step_reg + 4'd1;
                        end
                    end
                    default:
                    begin
                        is_data_next = 1'b1;
                        if (!low_byte_next_reg)
                        begin
                            spi_byte_next      = held_color_reg[15:8];
                            low_byte_next_next = 1'b1;
                        end
                        else
                        begin
                            spi_byte_next      = held_color_reg[7:0];
                            low_byte_next_next = 1'b0;
                            if (cols_left_reg <= ONE_C)
                            begin
                                if (rows_left_reg <= ONE_C)
                                begin
                                    last_next      = 1'b1;
                                    busy_next      = 1'b0;
                                    mode_next      = MODE_RAW;
                                    rows_left_next = '0;
                                    cols_left_next = '0;
                                end
                                else
                                begin
                                    rows_left_next = rows_left_reg - ONE_C;
                                    cols_left_next = cols_in_row_reg;
                                end
                            end
                            else
                            begin
                                cols_left_next = cols_left_reg - ONE_C;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_width_reg   <= PANEL_WIDTH_RST;
            panel_height_reg  <= PANEL_HEIGHT_RST;
            busy_reg          <= 1'b0;
            mode_reg          <= MODE_RAW;
            header_step_reg   <= '0;
            held_byte_reg     <= '0;
            held_is_data_reg  <= 1'b0;
            x0_reg            <= '0;
            x1_reg            <= '0;
            y0_reg            <= '0;
            y1_reg            <= '0;
            held_color_reg    <= '0;
            cols_in_row_reg   <= '0;
            cols_left_reg     <= '0;
            rows_left_reg     <= '0;
            low_byte_next_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            spi_byte_reg      <= '0;
            is_data_reg       <= 1'b0;
            last_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_PANEL_WIDTH)
                begin
                    panel_width_reg <= cfg_data;
                end
                else
                begin
                    panel_height_reg <= cfg_data;
                end
            end
            busy_reg          <= busy_next;
            mode_reg          <= mode_next;
            header_step_reg   <= header_step_next;
            held_byte_reg     <= held_byte_next;
            held_is_data_reg  <= held_is_data_next;
            x0_reg            <= x0_next;
            x1_reg            <= x1_next;
            y0_reg            <= y0_next;
            y1_reg            <= y1_next;
            held_color_reg    <= held_color_next;
            cols_in_row_reg   <= cols_in_row_next;
            cols_left_reg     <= cols_left_next;
            rows_left_reg     <= rows_left_next;
            low_byte_next_reg <= low_byte_next_next;
            out_valid_reg     <= out_valid_next;
            spi_byte_reg      <= spi_byte_next;
            is_data_reg       <= is_data_next;
            last_reg          <= last_next;
        end
    end

    // A tick taken with a sequence pending always yields a byte
    a_tick_gives_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && command == CMD_TICK && busy_reg |=> out_valid_reg)
        else $error("tick with pending sequence produced no byte");

    // Pixel phase only with a non-empty window
    a_pix_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_PIX |-> busy_reg && cols_in_row_reg != '0 &&
            rows_left_reg != '0 && cols_left_reg <= cols_in_row_reg)
        else $error("pixel phase with empty or inconsistent counters");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_step_reg <= STEP_RAMWR)
        else $error("header step out of range");

    // Colour byte phase restarts on the high byte once a sequence ends
    a_idle_high_byte: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !low_byte_next_reg)
        else $error("idle with low colour byte pending");

endmodule

`default_nettype wire
